// ===== design/linear_interp_resampler_fifo_defines.svh =====
// Assertion macros for the resampler block
`ifndef LINEAR_INTERP_RESAMPLER_FIFO_DEFINES_SVH
`define LINEAR_INTERP_RESAMPLER_FIFO_DEFINES_SVH

// same-cycle implication under reset
`define LIRF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under reset
`define LIRF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/lirf_pkg.sv =====
// Shared types, constants and helpers for the resampler block
`default_nettype none

package lirf_pkg;

    localparam int FIFO_DEPTH = 1024;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int SMP_W      = 24;
    localparam int FRAC_W     = 24;
    localparam int STEP_W     = 27;
    localparam int PHASE_W    = 28;
    localparam int WHOLE_W    = PHASE_W - FRAC_W;
    localparam int DIFF_W     = SMP_W + 1;
    localparam int PROD_W     = DIFF_W + FRAC_W + 1;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_PULL = 1'b1;

    localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(1) << FRAC_W;
    localparam logic [STEP_W-1:0]  STEP_ONE  = STEP_W'(1) << FRAC_W;

    typedef logic [PTR_W-1:0]        ptr_t;
    typedef logic [CNT_W-1:0]        cnt_t;
    typedef logic signed [SMP_W-1:0] smp_t;

    typedef struct packed {
        logic kind;
        smp_t sample_in;
    } req_t;

    typedef struct packed {
        logic kind_echo;
        logic accepted;
        smp_t sample_out;
        logic underrun;
    } rsp_t;

    typedef struct packed {
        logic mul_en;
        logic sum_en;
    } interp_ctl_t;

    function automatic ptr_t ptr_inc(input ptr_t p);
        ptr_t r;
        if (p == PTR_W'(FIFO_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/lirf_ram.sv =====
// Sample storage: one write port, one registered read port
`default_nettype none

module lirf_ram (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire lirf_pkg::ptr_t waddr,
    input  wire lirf_pkg::smp_t wdata,
    input  wire logic          re,
    input  wire lirf_pkg::ptr_t raddr,
    output lirf_pkg::smp_t     rdata
);

    lirf_pkg::smp_t mem [lirf_pkg::FIFO_DEPTH];
    lirf_pkg::smp_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== design/lirf_interp.sv =====
// Interpolation datapath: registered product, then registered sum
`default_nettype none

module lirf_interp (
    input  wire logic                 clk,
    input  wire lirf_pkg::interp_ctl_t ctl,
    input  wire logic [lirf_pkg::FRAC_W-1:0] frac,
    input  wire lirf_pkg::smp_t       prev_smp,
    input  wire lirf_pkg::smp_t       curr_smp,
    output lirf_pkg::smp_t            result
);

    logic signed [lirf_pkg::DIFF_W-1:0] diff;
    logic signed [lirf_pkg::FRAC_W:0]   frac_s;
    logic signed [lirf_pkg::PROD_W-1:0] prod;
    logic signed [lirf_pkg::PROD_W-1:0] prod_reg;
    lirf_pkg::smp_t                     result_reg;

    assign diff   = lirf_pkg::DIFF_W'(curr_smp) - lirf_pkg::DIFF_W'(prev_smp);
    assign frac_s = $signed({1'b0, frac});
    assign prod   = lirf_pkg::PROD_W'(frac_s) * lirf_pkg::PROD_W'(diff);

    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
        begin
            prod_reg <= prod;
        end
    end

    // floor shift by the fraction width, keep the low sample bits
    always_ff @(posedge clk)
    begin
        if (ctl.sum_en)
        begin
            result_reg <= prev_smp
                + prod_reg[lirf_pkg::FRAC_W +: lirf_pkg::SMP_W];
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

// ===== design/linear_interp_resampler_fifo.sv =====
// Linear-interpolation resampler with input sample FIFO (top level)
//
// Request channel (req_valid / req_stall / req): a push beat (kind 0) stores
// sample_in in a 1024-entry FIFO and answers accepted, 0 when full. A pull
// beat (kind 1) pops one sample per whole unit of phase, then returns
// prev + frac * (curr - prev) with floor rounding and adds step_ratio.
// Response channel (rsp_valid / rsp_stall / rsp): one beat per request,
// in order. cfg_we / cfg_wdata write step_ratio; the user must write it
// only while the block is idle, as the block itself does not enforce it.
// One item is in work at a time. A push goes from accept to DONE, which
// loads the output register; a pull steps LOOP once per whole phase unit,
// with a WAIT state for the registered memory read on each pop, then MUL,
// SUM and DONE (at most eight pops per pull). The next request is taken
// in the cycle after DONE loads the output register.
// The output register lets the next request be taken while a response is
// stalled; a finished item waits in its last state until that register frees.
// Reset clears pointers, fill count, samples and sets phase and step to 1.0;
// FIFO contents are undefined until written and never read before that.
`default_nettype none
`include "linear_interp_resampler_fifo_defines.svh"

module linear_interp_resampler_fifo (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    output logic                      req_stall,
    input  wire lirf_pkg::req_t       req,
    output logic                      rsp_valid,
    input  wire logic                 rsp_stall,
    output lirf_pkg::rsp_t            rsp,
    input  wire logic                 cfg_we,
    input  wire logic [lirf_pkg::STEP_W-1:0] cfg_wdata
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_LOOP = 6'b000010,
        S_WAIT = 6'b000100,
        S_MUL  = 6'b001000,
        S_SUM  = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    lirf_pkg::ptr_t rd_ptr_reg, rd_ptr_next;
    lirf_pkg::ptr_t wr_ptr_reg, wr_ptr_next;
    lirf_pkg::cnt_t fill_reg, fill_next;
    logic [lirf_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [lirf_pkg::STEP_W-1:0]  step_reg;
    lirf_pkg::smp_t prev_reg, prev_next;
    lirf_pkg::smp_t curr_reg, curr_next;
    logic [lirf_pkg::WHOLE_W-1:0] whole_reg, whole_next;
    logic kind_reg, kind_next;
    logic acc_reg, acc_next;
    logic und_reg, und_next;
    logic rsp_valid_reg, rsp_valid_next;
    lirf_pkg::rsp_t rsp_reg;
    logic rsp_load;

    logic ram_we;
    logic ram_re;
    lirf_pkg::smp_t ram_rdata;
    lirf_pkg::smp_t interp_result;
    lirf_pkg::interp_ctl_t ictl;

    lirf_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_ptr_reg),
        .wdata (req.sample_in),
        .re    (ram_re),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    lirf_interp u_interp (
        .clk      (clk),
        .ctl      (ictl),
        .frac     (phase_reg[lirf_pkg::FRAC_W-1:0]),
        .prev_smp (prev_reg),
        .curr_smp (curr_reg),
        .result   (interp_result)
    );

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        rd_ptr_next    = rd_ptr_reg;
        wr_ptr_next    = wr_ptr_reg;
        fill_next      = fill_reg;
        phase_next     = phase_reg;
        prev_next      = prev_reg;
        curr_next      = curr_reg;
        whole_next     = whole_reg;
        kind_next      = kind_reg;
        acc_next       = acc_reg;
        und_next       = und_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_load       = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ictl           = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    kind_next = req.kind;
                    acc_next  = 1'b0;
                    und_next  = 1'b0;
                    if (req.kind == lirf_pkg::KIND_PUSH)
                    begin
                        if (fill_reg < lirf_pkg::CNT_W'(lirf_pkg::FIFO_DEPTH))
                        begin
                            ram_we      = 1'b1;
                            wr_ptr_next = lirf_pkg::ptr_inc(wr_ptr_reg);
                            fill_next   = fill_reg + lirf_pkg::CNT_W'(1);
                            acc_next    = 1'b1;
                        end
                        state_next = S_DONE;
                    end
                    else
                    begin
                        whole_next = phase_reg[lirf_pkg::PHASE_W-1:lirf_pkg::FRAC_W];
                        state_next = S_LOOP;
                    end
                end
            end
            S_LOOP:
            begin
                if (whole_reg == '0)
                begin
                    state_next = S_MUL;
                end
                else
                begin
                    prev_next  = curr_reg;
                    whole_next = whole_reg - lirf_pkg::WHOLE_W'(1);
                    if (fill_reg != '0)
                    begin
                        ram_re      = 1'b1;
                        rd_ptr_next = lirf_pkg::ptr_inc(rd_ptr_reg);
                        fill_next   = fill_reg - lirf_pkg::CNT_W'(1);
                        state_next  = S_WAIT;
                    end
                    else
                    begin
                        und_next = 1'b1;
                    end
                end
            end
            S_WAIT:
            begin
                curr_next  = ram_rdata;
                state_next = S_LOOP;
            end
            S_MUL:
            begin
                ictl.mul_en = 1'b1;
                phase_next  = lirf_pkg::PHASE_W'(phase_reg[lirf_pkg::FRAC_W-1:0])
                            + lirf_pkg::PHASE_W'(step_reg);
                state_next  = S_SUM;
            end
            S_SUM:
            begin
                ictl.sum_en = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_load       = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            fill_reg      <= '0;
            phase_reg     <= lirf_pkg::PHASE_ONE;
            step_reg      <= lirf_pkg::STEP_ONE;
            prev_reg      <= '0;
            curr_reg      <= '0;
            whole_reg     <= '0;
            kind_reg      <= 1'b0;
            acc_reg       <= 1'b0;
            und_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            fill_reg      <= fill_next;
            phase_reg     <= phase_next;
            prev_reg      <= prev_next;
            curr_reg      <= curr_next;
            whole_reg     <= whole_next;
            kind_reg      <= kind_next;
            acc_reg       <= acc_next;
            und_reg       <= und_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                step_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load)
        begin
            rsp_reg.kind_echo  <= kind_reg;
            rsp_reg.accepted   <= acc_reg;
            rsp_reg.sample_out <= (kind_reg == lirf_pkg::KIND_PULL) ? interp_result : '0;
            rsp_reg.underrun   <= und_reg;
        end
    end

    `LIRF_ASSERT_NOW(a_pop_not_empty, clk, rst_n, ram_re, fill_reg != '0, "pop from empty FIFO")
    `LIRF_ASSERT_NEXT(a_pop_waits, clk, rst_n, ram_re, state_reg == S_WAIT, "pop without read wait")
    `LIRF_ASSERT_NEXT(a_accept_busy, clk, rst_n, req_valid && !req_stall, state_reg != S_IDLE, "accepted beat left block idle")
    `LIRF_ASSERT_NOW(a_push_rsp, clk, rst_n, rsp_valid && (rsp.kind_echo == lirf_pkg::KIND_PUSH), (rsp.sample_out == '0) && !rsp.underrun, "push response carries pull fields")

endmodule

`default_nettype wire

// ===== tb/linear_interp_resampler_fifo_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the linear-interpolation resampler with sample FIFO
module linear_interp_resampler_fifo_test;
    import lirf_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE_TICKS = 40;
    localparam logic [STEP_W-1:0] STEP_MAX  = '1;
    localparam logic [STEP_W-1:0] STEP_MIN  = STEP_W'(1);
    localparam logic [STEP_W-1:0] STEP_ZERO = '0;
    localparam logic [STEP_W-1:0] STEP_HALF = STEP_W'(1) << (FRAC_W - 1);

    typedef enum logic [1:0] {ROW_PUSH, ROW_PULL, ROW_STEP} row_op_t;

    typedef struct packed {
        row_op_t     op;
        logic [31:0] data;
        logic        pinned;
        rsp_t        answer;
    } row_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              req_valid = 1'b0;
    logic              req_stall;
    req_t              req       = '0;
    logic              rsp_valid;
    logic              rsp_stall = 1'b0;
    rsp_t              rsp;
    logic              cfg_we    = 1'b0;
    logic [STEP_W-1:0] cfg_wdata = '0;

    logic steady   = 1'b0;
    logic hold_arm = 1'b0;
    int   hold_left = 0;
    logic pin_en   = 1'b0;
    rsp_t pin_rsp  = '0;

    smp_t              fifo_mem [FIFO_DEPTH];
    ptr_t              rd_ptr;
    ptr_t              wr_ptr;
    cnt_t              fill_cnt;
    logic [PHASE_W-1:0] phase_acc;
    logic [STEP_W-1:0] step_reg;
    smp_t              prev_smp;
    smp_t              curr_smp;

    rsp_t pending_rsp [$];
    row_t script [$];
    int   sent        = 0;
    int   answered    = 0;
    int   errors      = 0;
    int   cycle_count = 0;

    linear_interp_resampler_fifo u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("linear_interp_resampler_fifo_test: done, errors");
            $finish;
        end
    end

    function automatic rsp_t resample(input req_t item);
        rsp_t               r;
        logic [FRAC_W-1:0]  frac;
        longint             diff;
        longint             prod;
        r = '0;
        r.kind_echo = item.kind;
        if (item.kind == KIND_PUSH)
        begin
            if (fill_cnt < FIFO_DEPTH)
            begin
                fifo_mem[wr_ptr] = item.sample_in;
                wr_ptr = (wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
                fill_cnt = fill_cnt + 1'b1;
                r.accepted = 1'b1;
            end
        end
        else
        begin
            while (phase_acc >= PHASE_ONE)
            begin
                prev_smp = curr_smp;
                if (fill_cnt != 0)
                begin
                    curr_smp = fifo_mem[rd_ptr];
                    rd_ptr = (rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
                    fill_cnt = fill_cnt - 1'b1;
                end
                else
                begin
                    r.underrun = 1'b1;
                end
                phase_acc = phase_acc - PHASE_ONE;
            end
            frac = phase_acc[FRAC_W-1:0];
            diff = longint'(curr_smp) - longint'(prev_smp);
            prod = longint'(frac) * diff;
            r.sample_out = smp_t'(longint'(prev_smp) + (prod >>> FRAC_W));
            phase_acc = phase_acc + PHASE_W'(step_reg);
        end
        return r;
    endfunction

    task automatic flag_error(input string what, input rsp_t want, input rsp_t got);
        errors++;
        if (errors <= 10)
        begin
            $display("%s at beat %0d: want kind %0d acc %0d smp %0d ur %0d",
                     what, answered, want.kind_echo, want.accepted, want.sample_out,
                     want.underrun);
            $display("    got kind %0d acc %0d smp %0d ur %0d",
                     got.kind_echo, got.accepted, got.sample_out, got.underrun);
        end
    endtask

    always @(posedge clk)
    begin : watch
        rsp_t want;
        if (!rst_n)
        begin
            rd_ptr    = '0;
            wr_ptr    = '0;
            fill_cnt  = '0;
            phase_acc = PHASE_ONE;
            step_reg  = STEP_ONE;
            prev_smp  = '0;
            curr_smp  = '0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (pending_rsp.size() == 0)
                begin
                    flag_error("unexpected response", '0, rsp);
                end
                else
                begin
                    want = pending_rsp.pop_front();
                    if (rsp.kind_echo !== want.kind_echo || rsp.accepted !== want.accepted ||
                        rsp.sample_out !== want.sample_out || rsp.underrun !== want.underrun)
                    begin
                        flag_error("mismatch", want, rsp);
                    end
                    answered++;
                end
            end
            if (cfg_we)
            begin
                step_reg = cfg_wdata;
            end
            if (req_valid && !req_stall)
            begin
                want = resample(req);
                if (pin_en)
                begin
                    want = pin_rsp;
                end
                pending_rsp.push_back(want);
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_arm)
        begin
            hold_arm  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            rsp_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
        end
        else
        begin
            rsp_stall <= !steady && ($urandom_range(99) < 27);
        end
    end

    function automatic rsp_t answer_of(input logic kind, input logic acc, input smp_t s,
                                       input logic ur);
        rsp_t a;
        a.kind_echo  = kind;
        a.accepted   = acc;
        a.sample_out = s;
        a.underrun   = ur;
        return a;
    endfunction

    function automatic void add_row(input row_op_t op, input int data, input logic pinned,
                                    input rsp_t answer);
        row_t r;
        r.op     = op;
        r.data   = data;
        r.pinned = pinned;
        r.answer = answer;
        script.push_back(r);
    endfunction

    function automatic smp_t pick_sample();
        smp_t s;
        case ($urandom_range(9))
            0: s = 24'h7FFFFF;
            1: s = 24'h800000;
            2: s = '0;
            3: s = 24'hFFFFFF;
            default: s = smp_t'($urandom);
        endcase
        return s;
    endfunction

    task automatic offer(input logic kind, input smp_t sample, input logic pinned,
                         input rsp_t answer);
        req_t beat;
        beat.kind      = kind;
        beat.sample_in = sample;
        while (!steady && $urandom_range(99) < 27)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= beat;
        pin_en    <= pinned;
        pin_rsp   <= answer;
        @(posedge clk);
        while (req_stall)
        begin
            @(posedge clk);
        end
        sent++;
    endtask

    task automatic drain_results();
        req_valid <= 1'b0;
        while (answered != sent)
        begin
            @(posedge clk);
        end
    endtask

    task automatic set_step(input logic [STEP_W-1:0] value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_phase(input logic [STEP_W-1:0] value, input int items, input int push_pct);
        set_step(value);
        repeat (items)
        begin
            offer(($urandom_range(99) < push_pct) ? KIND_PUSH : KIND_PULL, pick_sample(),
                  1'b0, '0);
        end
    endtask

    initial
    begin
        row_t r;
        rsp_t pushed;
        pushed = answer_of(KIND_PUSH, 1'b1, '0, 1'b0);

        add_row(ROW_PULL, 24'h123456, 1'b1, answer_of(KIND_PULL, 1'b0, '0, 1'b1));
        add_row(ROW_PUSH, 24'h7FFFFF, 1'b1, pushed);
        add_row(ROW_PUSH, 24'h800000, 1'b1, pushed);
        add_row(ROW_PULL, 24'h000000, 1'b1, answer_of(KIND_PULL, 1'b0, '0, 1'b0));
        add_row(ROW_PULL, 24'hFFFFFF, 1'b1, answer_of(KIND_PULL, 1'b0, 24'h7FFFFF, 1'b0));
        add_row(ROW_PULL, 24'h000000, 1'b1, answer_of(KIND_PULL, 1'b0, 24'h800000, 1'b1));
        add_row(ROW_STEP, STEP_HALF, 1'b0, '0);
        add_row(ROW_PUSH, 24'h0003E8, 1'b1, pushed);
        add_row(ROW_PUSH, 24'hFFFC18, 1'b1, pushed);
        add_row(ROW_PUSH, 24'h5A5A5A, 1'b1, pushed);
        add_row(ROW_PULL, 24'h000000, 1'b0, '0);
        add_row(ROW_PULL, 24'hA5A5A5, 1'b0, '0);
        add_row(ROW_PULL, 24'h000000, 1'b0, '0);
        add_row(ROW_PULL, 24'h000000, 1'b0, '0);
        add_row(ROW_STEP, STEP_MAX, 1'b0, '0);
        add_row(ROW_PUSH, 24'h000001, 1'b1, pushed);
        add_row(ROW_PUSH, 24'hFFFFFF, 1'b1, pushed);
        add_row(ROW_PUSH, 24'h555555, 1'b1, pushed);
        add_row(ROW_PUSH, 24'hAAAAAA, 1'b1, pushed);
        add_row(ROW_PULL, 24'h000000, 1'b0, '0);
        add_row(ROW_PULL, 24'h000000, 1'b0, '0);
        add_row(ROW_STEP, STEP_ZERO, 1'b0, '0);
        add_row(ROW_PULL, 24'h000000, 1'b0, '0);
        add_row(ROW_PULL, 24'h000000, 1'b0, '0);
        add_row(ROW_STEP, STEP_MIN, 1'b0, '0);
        add_row(ROW_PULL, 24'h000000, 1'b0, '0);
        add_row(ROW_PUSH, 24'h2AAAAA, 1'b0, '0);
        add_row(ROW_PULL, 24'h000000, 1'b0, '0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < script.size(); i++)
        begin
            r = script[i];
            if (r.op == ROW_STEP)
            begin
                set_step(r.data[STEP_W-1:0]);
            end
            else
            begin
                offer((r.op == ROW_PULL) ? KIND_PULL : KIND_PUSH, r.data[SMP_W-1:0],
                      r.pinned, r.answer);
            end
        end

        steady <= 1'b1;
        run_phase(STEP_ONE, 16, 50);
        steady <= 1'b0;
        run_phase(STEP_MAX, 10, 85);
        run_phase(STEP_ZERO, 6, 40);
        run_phase(STEP_MIN, 8, 20);
        run_phase(STEP_W'($urandom_range(134217727, 1)), 8, 60);
        run_phase(STEP_W'($urandom_range(16777215, 1)), 10, 30);

        // fill the sample store past full; the output side holds off at the start
        set_step(STEP_W'($urandom_range(33554431, 16777216)));
        hold_arm <= 1'b1;
        repeat (FIFO_DEPTH - int'(fill_cnt) + 3)
        begin
            offer(KIND_PUSH, pick_sample(), 1'b0, '0);
        end
        steady <= 1'b1;
        run_phase(STEP_MAX, 40, 10);
        steady <= 1'b0;
        run_phase(STEP_ONE, 6, 50);

        drain_results();
        repeat (SETTLE_TICKS) @(posedge clk);
        if (errors == 0 && pending_rsp.size() == 0)
        begin
            $display("linear_interp_resampler_fifo_test: done, clean");
        end
        else
        begin
            $display("linear_interp_resampler_fifo_test: done, errors");
        end
        $finish;
    end

endmodule
